// ===== rtl/pgtd_pkg.sv =====
package pgtd_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int TABLE_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int ENTRY_W     = 16;
  // trial divisors run one past the last 16-bit table prime
  localparam int DIV_W       = ENTRY_W + 1;
  localparam int BITCNT_W    = $clog2(VALUE_WIDTH);

  localparam logic [VALUE_WIDTH-1:0] LIMIT_RESET = VALUE_WIDTH'(64);
  localparam logic [VALUE_WIDTH-1:0] FIRST_PRIME = VALUE_WIDTH'(2);
  localparam logic [VALUE_WIDTH-1:0] FIRST_ODD   = VALUE_WIDTH'(3);
  // a candidate at or above this value cannot advance by two
  localparam logic [VALUE_WIDTH-1:0] TOP_VALUE   = {{(VALUE_WIDTH-1){1'b1}}, 1'b0};
  localparam logic [VALUE_WIDTH-1:0] ENTRY_MAX   =
    VALUE_WIDTH'({ENTRY_W{1'b1}});

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_LOAD,
    S_DIV,
    S_JUDGE,
    S_EMIT
  } state_t;

endpackage

// ===== rtl/prime_generator_trial_division_core.sv =====
// Trial-division prime generator.
// Input channel (in_valid / in_stall, field restart): each transfer yields
// exactly one result on the output channel (out_valid / out_stall, fields
// prime_value, prime_valid, done_res). restart=1 clears the prime table and
// the last prime and returns an all-zero result; restart=0 asks for the next
// prime below limit. The first request gives 2 (when limit exceeds 2), then
// odd candidates from 3. done_res=1 with prime_value=0 means no prime is left
// below limit; raising limit lets the search continue.
// limit is written through cfg_wr_en / cfg_wr_data; the user must do so only
// while the block is idle, which the block does not enforce. It resets to 64.
// Each trial divisor costs one bit-serial division in S_DIV, plus the table
// read in S_READ and S_LOAD when the divisor comes from the table, and the
// judgement in S_JUDGE. Each candidate adds S_CHECK, and each item adds S_IDLE
// (accept) and S_EMIT (result load). Divisors are tried up to the square root
// of the candidate; a restart, the first prime and done at top go straight from
// S_IDLE to S_EMIT. One item is worked at a time; in_stall is low
// only while the block is waiting for a request, which may be while the
// previous result still sits in the output register.
// Reset (rst, synchronous) empties the table and returns to the first prime.
// While out_valid and out_stall are both high the result is held and no new result is loaded.
module prime_generator_trial_division_core
  import pgtd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [VALUE_WIDTH-1:0] cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   restart,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] prime_value,
  output logic                   prime_valid,
  output logic                   done_res
);

  state_t state, state_next;

  logic [VALUE_WIDTH-1:0] limit;
  logic [VALUE_WIDTH-1:0] candidate;
  logic [COUNT_W-1:0]     table_count;
  logic [VALUE_WIDTH-1:0] cand_test;
  logic [ADDR_W-1:0]      idx;
  logic                   use_table;
  logic [DIV_W-1:0]       divisor;
  logic [DIV_W-1:0]       rem;
  logic [VALUE_WIDTH-1:0] dvd;
  logic [BITCNT_W-1:0]    bit_cnt;
  logic [VALUE_WIDTH-1:0] res_value;
  logic                   res_valid;
  logic                   res_done;

  logic [ENTRY_W-1:0] prime_table [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic               tbl_rd_en;
  logic               tbl_wr_en;
  logic [ENTRY_W-1:0] tbl_wr_data;

  logic               accept;
  logic               slot_free;
  logic               table_room;
  logic               cand_at_top;
  logic               test_at_top;
  logic               prime_hit;
  logic               divides;
  logic               more_table;
  logic               div_last;
  logic               div_start;
  logic [DIV_W:0]     trial;
  logic               trial_ge;
  logic [DIV_W-1:0]   next_divisor;

  assign accept       = in_valid && !in_stall;
  assign slot_free    = !out_valid || !out_stall;
  assign table_room   = table_count < COUNT_W'(TABLE_DEPTH);
  assign cand_at_top  = candidate >= TOP_VALUE;
  assign test_at_top  = cand_test >= TOP_VALUE;
  assign prime_hit    = VALUE_WIDTH'(divisor) > dvd;
  assign divides      = rem == '0;
  assign more_table   = use_table && ((COUNT_W'(idx) + COUNT_W'(1)) < table_count);
  assign div_last     = bit_cnt == BITCNT_W'(VALUE_WIDTH - 1);
  assign div_start    = (state_next == S_DIV) && (state != S_DIV);
  assign trial        = {rem, dvd[VALUE_WIDTH-1]};
  assign trial_ge     = trial >= {1'b0, divisor};
  assign next_divisor = (divisor == DIV_W'(2)) ? DIV_W'(3) : divisor + DIV_W'(2);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (restart || candidate == '0 || cand_at_top) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (cand_test >= limit) begin
          state_next = S_EMIT;
        end else if (table_count == '0) begin
          state_next = S_DIV;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_LOAD;
      S_LOAD:  state_next = S_DIV;
      S_DIV: begin
        if (div_last) begin
          state_next = S_JUDGE;
        end
      end
      S_JUDGE: begin
        if (prime_hit) begin
          state_next = S_EMIT;
        end else if (divides) begin
          state_next = test_at_top ? S_EMIT : S_CHECK;
        end else if (more_table) begin
          state_next = S_READ;
        end else begin
          state_next = S_DIV;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall    = 1'b1;
    tbl_rd_en   = 1'b0;
    tbl_wr_en   = 1'b0;
    tbl_wr_data = cand_test[ENTRY_W-1:0];
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        tbl_wr_data = FIRST_PRIME[ENTRY_W-1:0];
        tbl_wr_en   = accept && !restart && candidate == '0 &&
                      limit > FIRST_PRIME && table_room;
      end
      S_READ:  tbl_rd_en = 1'b1;
      S_JUDGE: tbl_wr_en = prime_hit && table_room && cand_test <= ENTRY_MAX;
      default: ;
    endcase
  end

  // prime table
  always_ff @(posedge clk) begin
    if (tbl_wr_en) begin
      prime_table[table_count[ADDR_W-1:0]] <= tbl_wr_data;
    end
    if (tbl_rd_en) begin
      rd_data <= prime_table[idx];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      limit       <= LIMIT_RESET;
      candidate   <= '0;
      table_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        limit <= cfg_wr_data;
      end
      if (tbl_wr_en) begin
        table_count <= table_count + COUNT_W'(1);
      end
      if (state == S_IDLE && accept) begin
        if (restart) begin
          candidate   <= '0;
          table_count <= '0;
        end else if (candidate == '0 && limit > FIRST_PRIME) begin
          candidate <= FIRST_PRIME;
        end
      end
      if (state == S_JUDGE && prime_hit) begin
        candidate <= cand_test;
      end
      if (state == S_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_value <= '0;
          res_valid <= 1'b0;
          res_done  <= 1'b0;
          if (!restart) begin
            if (candidate == '0) begin
              if (limit > FIRST_PRIME) begin
                res_value <= FIRST_PRIME;
                res_valid <= 1'b1;
              end else begin
                res_done <= 1'b1;
              end
            end else if (cand_at_top) begin
              res_done <= 1'b1;
            end else begin
              cand_test <= (candidate == FIRST_PRIME) ? FIRST_ODD
                                                      : candidate + VALUE_WIDTH'(2);
            end
          end
        end
      end
      S_CHECK: begin
        if (cand_test >= limit) begin
          res_value <= '0;
          res_valid <= 1'b0;
          res_done  <= 1'b1;
        end
        idx       <= '0;
        use_table <= table_count != '0;
        if (table_count == '0) begin
          divisor <= DIV_W'(2);
        end
      end
      S_LOAD: divisor <= {1'b0, rd_data};
      S_DIV: begin
        // one quotient bit per cycle; dvd shifts the dividend out and the quotient in
        if (trial_ge) begin
          rem <= DIV_W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[DIV_W-1:0];
        end
        dvd     <= {dvd[VALUE_WIDTH-2:0], trial_ge};
        bit_cnt <= bit_cnt + BITCNT_W'(1);
      end
      S_JUDGE: begin
        if (prime_hit) begin
          res_value <= cand_test;
          res_valid <= 1'b1;
          res_done  <= 1'b0;
        end else if (divides) begin
          if (test_at_top) begin
            res_value <= '0;
            res_valid <= 1'b0;
            res_done  <= 1'b1;
          end else begin
            cand_test <= cand_test + VALUE_WIDTH'(2);
          end
        end else if (more_table) begin
          idx <= idx + ADDR_W'(1);
        end else begin
          // table exhausted: walk odd divisors above its last entry
          use_table <= 1'b0;
          divisor   <= next_divisor;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          prime_value <= res_value;
          prime_valid <= res_valid;
          done_res    <= res_done;
        end
      end
      default: ;
    endcase
    if (div_start) begin
      rem     <= '0;
      dvd     <= cand_test;
      bit_cnt <= '0;
    end
  end

  a_result_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(prime_valid && done_res) && (prime_valid || prime_value == '0))
    else $error("result carries both a prime and done, or a stray value");

  a_table_bound: assert property (@(posedge clk) disable iff (rst)
    table_count <= COUNT_W'(TABLE_DEPTH))
    else $error("prime table count past depth");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> divisor >= DIV_W'(2))
    else $error("trial division with divisor below two");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    accept && restart |=> table_count == '0 && candidate == '0)
    else $error("restart did not clear table and candidate");

endmodule
